// ===== rtl/chunked_body_decoder_core_defines.svh =====
// assertion helpers shared by the decoder rtl
`ifndef CHUNKED_BODY_DECODER_CORE_DEFINES_SVH
`define CHUNKED_BODY_DECODER_CORE_DEFINES_SVH

// consequence holds in the same cycle as the antecedent
`define CBD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cbd assertion failed");

// consequence holds in the cycle after the antecedent
`define CBD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cbd assertion failed");

`endif

// ===== rtl/cbd_pkg.sv =====
package cbd_pkg;

    localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_SIZE  = 2'd1;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd2;
    localparam logic [1:0] ERR_FRAMING   = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  payload;
        logic [1:0]  err;
        logic [31:0] used;
        logic [31:0] total;
    } cbd_result_t;

endpackage

// ===== rtl/cbd_parser.sv =====
module cbd_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [7:0]         in_byte,
    input  logic               in_first,
    input  logic [31:0]        max_body_bytes,
    output cbd_pkg::cbd_result_t res
);
    import cbd_pkg::*;

    localparam logic [3:0] PH_SIZE         = 4'd0;
    localparam logic [3:0] PH_DATA         = 4'd1;
    localparam logic [3:0] PH_DATA_CR      = 4'd2;
    localparam logic [3:0] PH_DATA_LF      = 4'd3;
    localparam logic [3:0] PH_TRL_START    = 4'd4;
    localparam logic [3:0] PH_TRL_START_CR = 4'd5;
    localparam logic [3:0] PH_TRL_MID      = 4'd6;
    localparam logic [3:0] PH_DONE         = 4'd7;
    localparam logic [3:0] PH_ERROR        = 4'd8;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // {is_hex, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    logic [3:0]  phase_reg, phase_next, ph;
    logic [35:0] acc_reg, acc_next, acc;
    logic [32:0] rem_reg, rem_next, rem;
    logic [31:0] total_reg, total_next, tot;
    logic [31:0] cons_reg, cons_next, cons;
    logic        digit_reg, digit_next, digit;
    logic        stop_reg, stop_next, stop;
    logic        pcr_reg, pcr_next, pcr;
    logic [4:0]  hx;
    logic [36:0] sum;
    logic        is_cr, is_lf;

    always_comb begin
        // a start-of-body flag clears the state ahead of this byte
        ph    = in_first ? PH_SIZE : phase_reg;
        acc   = in_first ? '0 : acc_reg;
        rem   = in_first ? '0 : rem_reg;
        tot   = in_first ? '0 : total_reg;
        cons  = in_first ? '0 : cons_reg;
        digit = in_first ? 1'b0 : digit_reg;
        stop  = in_first ? 1'b0 : stop_reg;
        pcr   = in_first ? 1'b0 : pcr_reg;

        phase_next = ph;
        acc_next   = acc;
        rem_next   = rem;
        total_next = tot;
        cons_next  = cons;
        digit_next = digit;
        stop_next  = stop;
        pcr_next   = pcr;

        hx    = hex_digit(in_byte);
        sum   = {5'd0, tot} + {1'b0, acc};
        is_cr = (in_byte == CH_CR);
        is_lf = (in_byte == CH_LF);
        res   = '0;

        if (ph != PH_DONE && ph != PH_ERROR) begin
            if (cons != '1) begin
                cons_next = cons + 32'd1;
            end
            case (ph)
                PH_SIZE: begin
                    if (pcr && is_lf) begin
                        pcr_next   = 1'b0;
                        acc_next   = '0;
                        digit_next = 1'b0;
                        stop_next  = 1'b0;
                        if (!digit) begin
                            phase_next = PH_ERROR;
                            res.valid  = 1'b1;
                            res.kind   = KIND_ERROR;
                            res.err    = ERR_BAD_SIZE;
                            res.total  = tot;
                        end else if (acc == '0) begin
                            phase_next = PH_TRL_START;
                        end else if (sum > {5'd0, max_body_bytes}) begin
                            phase_next = PH_ERROR;
                            res.valid  = 1'b1;
                            res.kind   = KIND_ERROR;
                            res.err    = ERR_TOO_LARGE;
                            res.total  = tot;
                        end else begin
                            // size fits the 32-bit limit here
                            rem_next   = acc[32:0];
                            phase_next = PH_DATA;
                        end
                    end else begin
                        pcr_next = is_cr;
                        if (pcr) begin
                            // a lone cr is a non-hex line character
                            stop_next = 1'b1;
                        end else if (!is_cr && !stop) begin
                            if (in_byte == CH_SEMI) begin
                                stop_next = 1'b1;
                            end else if (hx[4]) begin
                                acc_next   = (acc[35:32] != 4'd0) ? '1 : {acc[31:0], hx[3:0]};
                                digit_next = 1'b1;
                            end else if (digit || (in_byte != CH_SPACE && in_byte != CH_TAB)) begin
                                stop_next = 1'b1;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    rem_next   = rem - 33'd1;
                    total_next = tot + 32'd1;
                    if (rem == 33'd1) begin
                        phase_next = PH_DATA_CR;
                    end
                    res.valid   = 1'b1;
                    res.kind    = KIND_PAYLOAD;
                    res.payload = in_byte;
                    res.total   = tot + 32'd1;
                end
                PH_DATA_CR, PH_DATA_LF: begin
                    if ((ph == PH_DATA_CR) ? !is_cr : !is_lf) begin
                        phase_next = PH_ERROR;
                        res.valid  = 1'b1;
                        res.kind   = KIND_ERROR;
                        res.err    = ERR_FRAMING;
                        res.total  = tot;
                    end else begin
                        phase_next = (ph == PH_DATA_CR) ? PH_DATA_LF : PH_SIZE;
                    end
                end
                PH_TRL_START: begin
                    if (is_cr) begin
                        phase_next = PH_TRL_START_CR;
                    end else begin
                        phase_next = PH_TRL_MID;
                        pcr_next   = 1'b0;
                    end
                end
                PH_TRL_START_CR: begin
                    if (is_lf) begin
                        phase_next = PH_DONE;
                        res.valid  = 1'b1;
                        res.kind   = KIND_DONE;
                        res.used   = cons_next;
                        res.total  = tot;
                    end else begin
                        phase_next = PH_TRL_MID;
                        pcr_next   = is_cr;
                    end
                end
                PH_TRL_MID: begin
                    if (pcr && is_lf) begin
                        pcr_next   = 1'b0;
                        phase_next = PH_TRL_START;
                    end else begin
                        pcr_next = is_cr;
                    end
                end
                default: begin
                    phase_next = PH_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SIZE;
            acc_reg   <= '0;
            rem_reg   <= '0;
            total_reg <= '0;
            cons_reg  <= '0;
            digit_reg <= 1'b0;
            stop_reg  <= 1'b0;
            pcr_reg   <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            total_reg <= total_next;
            cons_reg  <= cons_next;
            digit_reg <= digit_next;
            stop_reg  <= stop_next;
            pcr_reg   <= pcr_next;
        end
    end

endmodule

// ===== rtl/chunked_body_decoder_core.sv =====
// Chunked transfer body decoder, one body byte per transfer.
// Input stream s_*: s_tdata carries the body byte, s_tuser marks the first byte of
// a new body and restarts the decoder before that byte is parsed.
// Output stream m_*: m_tuser gives the result kind (payload byte, body complete,
// error); m_tdata carries payload byte, error code, bytes consumed and payload total.
// Many input bytes (size lines, crlf, trailers) produce no output transfer.
// Configuration: cfg_we writes cfg_wdata into the payload limit; write only when idle.
// Path: an accepted byte passes the input register, then the output register, before its
// result shows on m_tvalid; a full output slot holds it in the input register.
// Throughput: one byte per cycle while the output slot is free or m_tready is high; the
// byte parser updates all of its state per byte, so consecutive bytes flow without gaps.
// Reset (aresetn low, synchronous): parser state cleared, both stages empty, limit
// returns to 1048576.
// When m_tready is low the output register holds its result; the input register still
// takes one more byte, then s_tready drops until the output side moves again.
// After complete or error, bytes give no output until a byte with s_tuser high arrives.
module chunked_body_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] body_byte
    input  logic        s_tuser,   // [0] first_of_body
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] payload_byte, [9:8] error_code,
                                   // [41:10] bytes_consumed, [73:42] payload_total
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);
    import cbd_pkg::*;

    `include "chunked_body_decoder_core_defines.svh"

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;
    logic        out_valid_reg;
    cbd_result_t out_res_reg;
    cbd_result_t res;
    logic [31:0] max_body_reg;
    logic        process;

    // input stage drains whenever the output slot is free or being emptied
    assign process  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || process;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_body_reg <= MAX_BODY_RESET;
        end else if (cfg_we) begin
            max_body_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (process) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    cbd_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (process),
        .in_byte        (in_byte_reg),
        .in_first       (in_first_reg),
        .max_body_bytes (max_body_reg),
        .res            (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (process) begin
            out_valid_reg <= res.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (process && res.valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tdata  = {6'd0, out_res_reg.total, out_res_reg.used,
                       out_res_reg.err, out_res_reg.payload};

    `CBD_ASSERT_NOW(ap_drain_when_free, aclk, aresetn,
        in_valid_reg && !out_valid_reg, process)
    `CBD_ASSERT_NEXT(ap_result_lands, aclk, aresetn,
        process && res.valid, out_valid_reg && m_tuser == $past(res.kind))
    `CBD_ASSERT_NEXT(ap_accept_fills, aclk, aresetn,
        s_tvalid && s_tready, in_valid_reg)
    `CBD_ASSERT_NOW(ap_payload_clean, aclk, aresetn,
        m_tvalid && m_tuser == KIND_PAYLOAD,
        out_res_reg.err == ERR_NONE && out_res_reg.used == 32'd0)
    `CBD_ASSERT_NOW(ap_error_has_code, aclk, aresetn,
        m_tvalid && m_tuser == KIND_ERROR, out_res_reg.err != ERR_NONE)

endmodule

// ===== sim/tb_chunked_body_decoder_core.sv =====
`timescale 1ns / 100ps

module tb_chunked_body_decoder_core;
    import cbd_pkg::*;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;

    typedef enum logic [3:0] {
        LINE_SIZE, IN_CHUNK, CHUNK_CR, CHUNK_LF,
        TRAILER_START, TRAILER_CR, TRAILER_LINE, BODY_DONE, BODY_FAILED
    } parse_state_t;

    typedef struct {
        logic [7:0] data;
        logic       first;
    } body_item_t;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  payload;
        logic [1:0]  err;
        logic [31:0] used;
        logic [31:0] total;
    } decoded_result_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = 32'd0;

    // decoder model
    parse_state_t parse_state;
    logic [35:0]  size_acc;
    logic [32:0]  chunk_left;
    logic [31:0]  decoded_total;
    logic [31:0]  consumed;
    logic         digit_seen;
    logic         size_stopped;
    logic         prev_cr;
    logic [31:0]  limit_model;

    body_item_t      pending_bytes[$];
    decoded_result_t predicted_results[$];
    logic [7:0]      body_buf[$];

    int unsigned bytes_queued = 0;
    int unsigned bytes_shown  = 0;
    int unsigned bytes_taken  = 0;
    int unsigned results_seen = 0;
    int unsigned results_paced = 0;
    int unsigned mismatches   = 0;
    int unsigned payload_seen = 0;
    int unsigned done_seen    = 0;
    int unsigned errors_seen  = 0;
    int unsigned bodies_sent  = 0;
    int unsigned settings_used = 0;
    int unsigned s_wait = 0;
    int unsigned m_hold = 0;
    bit          s_steady = 1'b0;
    bit          m_steady = 1'b0;
    body_item_t  cur_item;

    chunked_body_decoder_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("timeout: %0d bytes taken of %0d, %0d results pending",
                 bytes_taken, bytes_queued, predicted_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic clear_decoder();
        parse_state   = LINE_SIZE;
        size_acc      = '0;
        chunk_left    = '0;
        decoded_total = '0;
        consumed      = '0;
        digit_seen    = 1'b0;
        size_stopped  = 1'b0;
        prev_cr       = 1'b0;
    endtask

    task automatic push_result(input logic [1:0] kind, input logic [7:0] payload,
                               input logic [1:0] err, input logic [31:0] used);
        decoded_result_t r;
        r.kind    = kind;
        r.payload = payload;
        r.err     = err;
        r.used    = used;
        r.total   = decoded_total;
        predicted_results.insert(predicted_results.size(), r);
    endtask

    task automatic fail_body(input logic [1:0] err);
        parse_state = BODY_FAILED;
        push_result(KIND_ERROR, 8'h00, err, 32'd0);
    endtask

    task automatic size_line_char(input logic [7:0] c);
        logic [39:0] grown;
        logic [3:0]  nib;
        logic        is_hex;
        is_hex = 1'b1;
        nib    = 4'd0;
        if (size_stopped) return;
        if (c == CH_SEMI) begin
            size_stopped = 1'b1;
            return;
        end
        if (c >= 8'h30 && c <= 8'h39) nib = 4'(c - 8'h30);       // 0-9
        else if (c >= 8'h41 && c <= 8'h46) nib = 4'(c - 8'h37);  // A-F
        else if (c >= 8'h61 && c <= 8'h66) nib = 4'(c - 8'h57);  // a-f
        else is_hex = 1'b0;
        if (is_hex) begin
            grown = {size_acc, 4'd0} | {36'd0, nib};
            size_acc = (grown > 40'h0F_FFFF_FFFF) ? 36'hF_FFFF_FFFF : grown[35:0];
            digit_seen = 1'b1;
        end else if (!(!digit_seen && (c == CH_SP || c == CH_TAB))) begin
            size_stopped = 1'b1;
        end
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic first);
        logic [35:0] size;
        logic        had;
        if (first) clear_decoder();
        if (parse_state == BODY_DONE || parse_state == BODY_FAILED) return;
        if (consumed != 32'hFFFF_FFFF) consumed++;
        case (parse_state)
            LINE_SIZE: begin
                if (prev_cr && c == CH_LF) begin
                    size         = size_acc;
                    had          = digit_seen;
                    prev_cr      = 1'b0;
                    size_acc     = '0;
                    digit_seen   = 1'b0;
                    size_stopped = 1'b0;
                    if (!had) begin
                        fail_body(ERR_BAD_SIZE);
                    end else if (size == 36'd0) begin
                        parse_state = TRAILER_START;
                    end else if ({32'd0, decoded_total} + {28'd0, size} >
                                 {32'd0, limit_model}) begin
                        fail_body(ERR_TOO_LARGE);
                    end else begin
                        chunk_left  = 33'(size);
                        parse_state = IN_CHUNK;
                    end
                end else begin
                    // a cr that is not part of cr lf is an ordinary line char
                    if (prev_cr) size_line_char(CH_CR);
                    prev_cr = (c == CH_CR);
                    if (!prev_cr) size_line_char(c);
                end
            end
            IN_CHUNK: begin
                chunk_left--;
                decoded_total++;
                if (chunk_left == 33'd0) parse_state = CHUNK_CR;
                push_result(KIND_PAYLOAD, c, ERR_NONE, 32'd0);
            end
            CHUNK_CR: begin
                if (c != CH_CR) fail_body(ERR_FRAMING);
                else parse_state = CHUNK_LF;
            end
            CHUNK_LF: begin
                if (c != CH_LF) fail_body(ERR_FRAMING);
                else parse_state = LINE_SIZE;
            end
            TRAILER_START: begin
                if (c == CH_CR) begin
                    parse_state = TRAILER_CR;
                end else begin
                    parse_state = TRAILER_LINE;
                    prev_cr     = 1'b0;
                end
            end
            TRAILER_CR: begin
                if (c == CH_LF) begin
                    parse_state = BODY_DONE;
                    push_result(KIND_DONE, 8'h00, ERR_NONE, consumed);
                end else begin
                    parse_state = TRAILER_LINE;
                    prev_cr     = (c == CH_CR);
                end
            end
            TRAILER_LINE: begin
                if (prev_cr && c == CH_LF) begin
                    prev_cr     = 1'b0;
                    parse_state = TRAILER_START;
                end else begin
                    prev_cr = (c == CH_CR);
                end
            end
            default: parse_state = BODY_FAILED;
        endcase
    endtask

    task automatic check_result();
        decoded_result_t want;
        results_seen++;
        if (predicted_results.size() == 0) begin
            flag_mismatch("result with none expected", {30'd0, m_tuser}, 32'd0);
            return;
        end
        want = predicted_results.pop_front();
        if (m_tuser != want.kind)
            flag_mismatch("result_kind", {30'd0, m_tuser}, {30'd0, want.kind});
        if (m_tdata[7:0] != want.payload)
            flag_mismatch("payload_byte", {24'd0, m_tdata[7:0]}, {24'd0, want.payload});
        if (m_tdata[9:8] != want.err)
            flag_mismatch("error_code", {30'd0, m_tdata[9:8]}, {30'd0, want.err});
        if (m_tdata[41:10] != want.used)
            flag_mismatch("bytes_consumed", m_tdata[41:10], want.used);
        if (m_tdata[73:42] != want.total)
            flag_mismatch("payload_total", m_tdata[73:42], want.total);
        case (want.kind)
            KIND_PAYLOAD: payload_seen++;
            KIND_DONE:    done_seen++;
            default:      errors_seen++;
        endcase
    endtask

    // model and checker, sampled at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_decoder();
            limit_model = MAX_BODY_RESET;
        end else begin
            if (cfg_we) limit_model = cfg_wdata;
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tuser);
                bytes_taken++;
            end
            if (m_tvalid && m_tready) check_result();
        end
    end

    // byte feeder
    always @(negedge aclk) begin
        if (aresetn && bytes_taken == bytes_shown) begin
            if (s_wait > 0) begin
                s_wait--;
                s_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                cur_item = pending_bytes.pop_front();
                s_tdata  <= cur_item.data;
                s_tuser  <= cur_item.first;
                s_tvalid <= 1'b1;
                bytes_shown++;
                if ($urandom_range(0, 31) == 0) s_steady = !s_steady;
                s_wait = s_steady ? 0 : $urandom_range(0, 19);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side backpressure, a new hold-off after every transfer
    always @(negedge aclk) begin
        if (results_seen != results_paced) begin
            results_paced = results_seen;
            if ($urandom_range(0, 31) == 0) m_steady = !m_steady;
            m_hold = m_steady ? 0 : $urandom_range(0, 19);
        end
        if (m_hold > 0) begin
            m_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic put_byte(input logic [7:0] b);
        body_buf.insert(body_buf.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic add_crlf();
        put_byte(CH_CR);
        put_byte(CH_LF);
    endtask

    task automatic add_hex_digits(input int unsigned n);
        string digits;
        digits = "0123456789abcdefABCDEF";
        repeat (n) put_byte(digits[$urandom_range(0, 21)]);
    endtask

    task automatic add_size_line(input int unsigned sz);
        string digits;
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
            put_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
        digits = $sformatf("%0h", sz);
        if ($urandom_range(0, 1)) digits = digits.toupper();
        if ($urandom_range(0, 4) == 0) digits = {"0", digits};
        add_text(digits);
        case ($urandom_range(0, 6))
            0: add_text(";ext=v");
            1: add_text(" ; q");
            2: begin
                put_byte(CH_CR);
                add_text("z");
            end
            3: add_text("-");
            default: ;
        endcase
        add_crlf();
    endtask

    task automatic add_trailer_line();
        case ($urandom_range(0, 3))
            0: put_byte(CH_CR);
            1: begin
                put_byte(CH_CR);
                add_text("t");
            end
            default: repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(32, 126)));
        endcase
        add_crlf();
    endtask

    task automatic make_body();
        int unsigned sz;
        body_buf.delete();
        repeat ($urandom_range(0, 3)) begin
            sz = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            add_size_line(sz);
            repeat (sz) put_byte(8'($urandom_range(0, 255)));
            add_crlf();
        end
        add_size_line(0);
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) add_trailer_line();
        add_crlf();
    endtask

    task automatic break_body();
        int unsigned at;
        at = $urandom_range(0, body_buf.size() - 1);
        case ($urandom_range(0, 5))
            0: body_buf[at] = 8'($urandom_range(0, 255));
            1: while (body_buf.size() > at + 1) void'(body_buf.pop_back());
            2: body_buf.insert(at, 8'($urandom_range(0, 255)));
            3: begin
                // chunk size far beyond any limit
                body_buf.delete();
                add_text("1");
                add_hex_digits($urandom_range(9, 12));
                add_crlf();
                add_text("data");
            end
            4: begin
                body_buf.delete();
                if ($urandom_range(0, 1)) add_text(";x");
                add_crlf();
            end
            default: begin
                // hex prefix is not understood: parses as size zero
                body_buf.delete();
                add_text("0x1A");
                add_crlf();
                add_text("abc");
                add_crlf();
                add_crlf();
            end
        endcase
    endtask

    task automatic queue_body();
        body_item_t it;
        foreach (body_buf[i]) begin
            it.data  = body_buf[i];
            it.first = (i == 0);
            pending_bytes.insert(pending_bytes.size(), it);
        end
        bytes_queued += body_buf.size();
        bodies_sent++;
    endtask

    task automatic queue_ignored(input int unsigned n);
        body_item_t it;
        repeat (n) begin
            it.data  = 8'($urandom_range(0, 255));
            it.first = 1'b0;
            pending_bytes.insert(pending_bytes.size(), it);
        end
        bytes_queued += n;
    endtask

    task automatic drain();
        int unsigned waited;
        waited = 0;
        while ((bytes_taken != bytes_queued || predicted_results.size() != 0) &&
               waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        if (predicted_results.size() != 0) begin
            flag_mismatch("results never arrived", 32'(predicted_results.size()), 32'd0);
            predicted_results.delete();
        end
        // bytes that give no result may still be in the pipeline
        repeat (6) @(negedge aclk);
    endtask

    task automatic set_limit(input logic [31:0] v);
        @(negedge aclk);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    initial begin
        logic [31:0]  limits[6];
        int unsigned  phase_start;
        int unsigned  pick;

        limits = '{32'hFFFF_FFFF, 32'd0, 32'd30, 32'd100, 32'd500, MAX_BODY_RESET};
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // extension, top payload byte, cr cr lf trailer, then an ignored byte
        body_buf.delete();
        add_text("1;e");
        add_crlf();
        put_byte(8'hFF);
        add_crlf();
        add_text("0");
        add_crlf();
        put_byte(CH_CR);
        add_crlf();
        add_crlf();
        queue_body();
        queue_ignored(1);
        // blanks then a sign: no digits
        body_buf.delete();
        put_byte(CH_SP);
        put_byte(CH_TAB);
        add_text("+5");
        add_crlf();
        queue_body();
        // saturating size
        body_buf.delete();
        add_text("fFfFfFfFfF");
        add_crlf();
        queue_body();
        // zero data byte, then no cr after the chunk
        body_buf.delete();
        add_text("1");
        add_crlf();
        put_byte(8'h00);
        add_text("X");
        queue_body();
        drain();

        foreach (limits[k]) begin
            set_limit(limits[k]);
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < 220) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    body_buf.delete();
                    repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(0, 255)));
                end else begin
                    make_body();
                    if (pick <= 5) break_body();
                end
                queue_body();
                if ($urandom_range(0, 7) == 0) queue_ignored($urandom_range(1, 3));
            end
            drain();
        end

        $display("sent %0d bodies, %0d bytes, under %0d payload limits plus the reset one",
                 bodies_sent, bytes_queued, settings_used);
        $display("checked %0d payload bytes, %0d completions, %0d errors",
                 payload_seen, done_seen, errors_seen);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cbd_pkg.sv
rtl/cbd_parser.sv
rtl/chunked_body_decoder_core.sv
sim/tb_chunked_body_decoder_core.sv
